@@ hdl/fixed_block_free_list_allocator_core_assert.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the free list allocator
// Shared helpers for the concurrent checks; all are clocked on clock and
// disabled during reset.
// ----------------------------------------------------------------------------
`ifndef FIXED_BLOCK_FREE_LIST_ALLOCATOR_CORE_ASSERT_SVH
`define FIXED_BLOCK_FREE_LIST_ALLOCATOR_CORE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define FBFL_ASSERT_SAME(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("fbfl check failed");

// The consequent must hold in the cycle after the antecedent.
`define FBFL_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("fbfl check failed");

`endif

@@ hdl/fbfl_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fbfl_pkg
// Types, sizes and codes shared by the free list allocator modules.
// ----------------------------------------------------------------------------
package fbfl_pkg;

   localparam int POOL_BLOCKS = 56;
   localparam int IDX_W       = 6;
   localparam int COUNT_W     = 6;
   localparam int STATUS_W    = 2;

   typedef logic [IDX_W-1:0]    idx_type;
   typedef logic [COUNT_W-1:0]  count_type;
   typedef logic [STATUS_W-1:0] status_type;

   // A link at or above the pool size ends the list.
   localparam idx_type   NULL_LINK  = idx_type'(POOL_BLOCKS);
   localparam idx_type   LAST_BLOCK = idx_type'(POOL_BLOCKS - 1);
   localparam count_type COUNT_MAX  = '1;
   localparam count_type COUNT_ZERO = '0;

   localparam logic ACT_ALLOC = 1'b0;
   localparam logic ACT_FREE  = 1'b1;

   localparam status_type STATUS_OK        = 2'd0;
   localparam status_type STATUS_EXHAUSTED = 2'd1;
   localparam status_type STATUS_FOREIGN   = 2'd2;

   typedef struct packed {
      logic    en;
      idx_type addr;
      idx_type data;
   } link_wr_type;

endpackage

@@ hdl/fbfl_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fbfl request and response channels
// Valid/ready channels carrying allocator requests and their results.
// ----------------------------------------------------------------------------
interface fbfl_req_if;
   logic              valid;
   logic              ready;
   logic              action;
   fbfl_pkg::idx_type block_index;

   modport source (output valid, output action, output block_index, input ready);
   modport sink (input valid, input action, input block_index, output ready);
endinterface

interface fbfl_rsp_if;
   logic                 valid;
   logic                 ready;
   fbfl_pkg::idx_type    granted_block;
   fbfl_pkg::status_type status;
   fbfl_pkg::count_type  in_use;

   modport source (output valid, output granted_block, output status, output in_use,
                   input ready);
   modport sink (input valid, input granted_block, input status, input in_use,
                 output ready);
endinterface

@@ hdl/fbfl_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fbfl_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module fbfl_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ hdl/fbfl_link_store.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fbfl_link_store
// Next-link memory of the free list, with per-entry valid bits so that an
// entry never written since reset reads as its initial chain value.
// ----------------------------------------------------------------------------
module fbfl_link_store (
   input  logic                  clock,
   input  logic                  reset,
   input  fbfl_pkg::idx_type     rd_addr,
   input  fbfl_pkg::link_wr_type wr,
   output fbfl_pkg::idx_type     rd_link
);

   logic [fbfl_pkg::POOL_BLOCKS-1:0] valid_ff;
   logic [fbfl_pkg::POOL_BLOCKS-1:0] valid_in;
   logic                             rd_valid_ff;
   logic                             rd_valid_in;
   fbfl_pkg::idx_type                rd_addr_ff;
   fbfl_pkg::idx_type                ram_q;
   fbfl_pkg::idx_type                init_link;

   fbfl_ram #(
      .WIDTH (fbfl_pkg::IDX_W),
      .DEPTH (fbfl_pkg::POOL_BLOCKS)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr.en),
      .wr_addr (wr.addr),
      .wr_data (wr.data),
      .rd_addr (rd_addr),
      .rd_data (ram_q)
   );

   always_comb begin
      valid_in = valid_ff;
      if (wr.en && (wr.addr < fbfl_pkg::NULL_LINK)) begin
         valid_in[wr.addr] = 1'b1;
      end
      rd_valid_in = (rd_addr < fbfl_pkg::NULL_LINK) ? valid_ff[rd_addr] : 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         valid_ff    <= valid_in;
         rd_valid_ff <= rd_valid_in;
      end
      rd_addr_ff <= rd_addr;
   end

   // After reset each block links to the next, and the last one ends the list.
   assign init_link = (rd_addr_ff == fbfl_pkg::LAST_BLOCK) ? fbfl_pkg::NULL_LINK
                                                           : rd_addr_ff + fbfl_pkg::idx_type'(1);
   assign rd_link   = rd_valid_ff ? ram_q : init_link;

endmodule

@@ hdl/fixed_block_free_list_allocator_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fixed_block_free_list_allocator_core
// Pool allocator of fixed blocks over a linked free list held in a RAM.
// ----------------------------------------------------------------------------
// Requests arrive on req_bus: action 0 allocates a block, action 1 frees the
// block named by block_index. Each request gives exactly one result on
// rsp_bus: the granted block, a status (ok, pool exhausted, foreign index)
// and the number of blocks in use after the request.
// A request is accepted in ST_IDLE, where the link of the current head is
// read from the link RAM; in ST_EXEC the read data returns and, once the
// output register is free, the list head and count are updated and the
// result is registered. Because the link read is registered, no new request
// is taken until the current one commits and leaves ST_EXEC.
// Reset clears the valid bits of the link store, so every block is chained in
// order with block 0 at the head; requests are taken as soon as reset is
// released.
// If the receiver stalls, the result is held in the output register; one
// further request may be accepted and waits in ST_EXEC until the output
// register is free.
// ----------------------------------------------------------------------------
module fixed_block_free_list_allocator_core (
   input logic clock,
   input logic reset,
   fbfl_req_if.sink   req_bus,
   fbfl_rsp_if.source rsp_bus
);

   typedef enum logic {
      ST_IDLE,
      ST_EXEC
   } state_type;

   state_type             state_ff, state_in;
   logic                  action_ff;
   fbfl_pkg::idx_type     index_ff;
   fbfl_pkg::idx_type     head_ff, head_in;
   logic                  empty_ff, empty_in;
   fbfl_pkg::count_type   count_ff, count_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   fbfl_pkg::idx_type     granted_ff, granted_in;
   fbfl_pkg::status_type  status_ff, status_in;
   fbfl_pkg::idx_type     link;
   fbfl_pkg::link_wr_type link_wr;
   logic                  accept;
   logic                  commit;

   fbfl_link_store u_link_store (
      .clock   (clock),
      .reset   (reset),
      .rd_addr (head_ff),
      .wr      (link_wr),
      .rd_link (link)
   );

   assign req_bus.ready = (state_ff == ST_IDLE);
   assign accept        = req_bus.valid && req_bus.ready;
   assign commit        = (state_ff == ST_EXEC) && (!rsp_valid_ff || rsp_bus.ready);

   always_comb begin
      state_in     = state_ff;
      head_in      = head_ff;
      empty_in     = empty_ff;
      count_in     = count_ff;
      granted_in   = granted_ff;
      status_in    = status_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_bus.ready;
      link_wr      = '0;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            if (commit) begin
               state_in     = ST_IDLE;
               rsp_valid_in = 1'b1;
               granted_in   = '0;
               status_in    = fbfl_pkg::STATUS_OK;
               if (action_ff == fbfl_pkg::ACT_ALLOC) begin
                  if (empty_ff || (head_ff >= fbfl_pkg::NULL_LINK)) begin
                     status_in = fbfl_pkg::STATUS_EXHAUSTED;
                  end else begin
                     granted_in = head_ff;
                     if (link >= fbfl_pkg::NULL_LINK) begin
                        empty_in = 1'b1;
                        head_in  = '0;
                     end else begin
                        head_in = link;
                     end
                     if (count_ff != fbfl_pkg::COUNT_MAX) begin
                        count_in = count_ff + fbfl_pkg::count_type'(1);
                     end
                  end
               end else begin
                  if (index_ff >= fbfl_pkg::NULL_LINK) begin
                     status_in = fbfl_pkg::STATUS_FOREIGN;
                  end else begin
                     link_wr.en   = 1'b1;
                     link_wr.addr = index_ff;
                     link_wr.data = empty_ff ? fbfl_pkg::NULL_LINK : head_ff;
                     head_in      = index_ff;
                     empty_in     = 1'b0;
                     if (count_ff != fbfl_pkg::COUNT_ZERO) begin
                        count_in = count_ff - fbfl_pkg::count_type'(1);
                     end
                  end
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         head_ff      <= '0;
         empty_ff     <= 1'b0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         empty_ff     <= empty_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      if (accept) begin
         action_ff <= req_bus.action;
         index_ff  <= req_bus.block_index;
      end
      granted_ff <= granted_in;
      status_ff  <= status_in;
   end

   assign rsp_bus.valid         = rsp_valid_ff;
   assign rsp_bus.granted_block = granted_ff;
   assign rsp_bus.status        = status_ff;
   assign rsp_bus.in_use        = count_ff;

endmodule

@@ hdl/fbfl_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fbfl_checker
// Port-level checks of the free list allocator, bound to the top level.
// ----------------------------------------------------------------------------
`include "fixed_block_free_list_allocator_core_assert.svh"

module fbfl_checker (
   input logic                 clock,
   input logic                 reset,
   input logic                 req_valid,
   input logic                 req_ready,
   input logic                 rsp_valid,
   input logic                 rsp_ready,
   input fbfl_pkg::idx_type    rsp_granted,
   input fbfl_pkg::status_type rsp_status,
   input fbfl_pkg::count_type  rsp_in_use
);

   // A held result must not change while the receiver stalls.
   `FBFL_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_granted) && $stable(rsp_status) && $stable(rsp_in_use))

   // An accepted request keeps the block from taking another while its link read returns.
   `FBFL_ASSERT_NEXT(a_two_cycle_item, req_valid && req_ready, !req_ready)

   // A result valid may only rise after an accepted request.
   `FBFL_ASSERT_SAME(a_rsp_latency, $rose(rsp_valid), $past(req_valid && req_ready, 2))

   // Only a successful allocation names a block.
   `FBFL_ASSERT_SAME(a_grant_zero, rsp_valid && (rsp_status != fbfl_pkg::STATUS_OK), rsp_granted == '0)

endmodule

bind fixed_block_free_list_allocator_core fbfl_checker u_fbfl_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_bus.valid),
   .req_ready   (req_bus.ready),
   .rsp_valid   (rsp_bus.valid),
   .rsp_ready   (rsp_bus.ready),
   .rsp_granted (rsp_bus.granted_block),
   .rsp_status  (rsp_bus.status),
   .rsp_in_use  (rsp_bus.in_use)
);
